// ===== rtl/bshp_pkg.sv =====
`default_nettype none

package bshp_pkg;

  // input item commands
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_EDGE  = 2'd1;
  localparam logic [1:0] CMD_SOLVE = 2'd2;

  localparam int NODE_CNT_W = 5;
  localparam logic [NODE_CNT_W-1:0] NODE_CNT_RESET = 5'd16;

  localparam int IN_WEIGHT_W = 16;

  // costs are held clamped to the output range
  localparam int COST_W = 20;
  localparam logic [COST_W-1:0] OUT_MAX = 20'hFFFFF;

  typedef struct packed {
    logic              reach;
    logic [COST_W-1:0] val;
  } cost_t;

  localparam cost_t COST_NONE = '{reach: 1'b0, val: '0};
  localparam cost_t COST_ZERO = '{reach: 1'b1, val: '0};

  typedef struct packed {
    logic  busy;
    logic  done;
    cost_t best;
  } sol_stat_t;

endpackage

`default_nettype wire

// ===== rtl/bshp_ram.sv =====
`default_nettype none

module bshp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/bshp_solver.sv =====
`default_nettype none

module bshp_solver import bshp_pkg::*; #(
  parameter int MAX_NODES = 16,
  parameter int EDGE_W = 16,
  localparam int NB = $clog2(MAX_NODES),
  localparam int NCW = $clog2(MAX_NODES + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              take,
  input  logic [NCW-1:0]    n_live,
  output logic [2*NB-1:0]   adj_raddr,
  input  logic [EDGE_W:0]   adj_rdata,
  output sol_stat_t         status
);

  localparam int TBL_AW = MAX_NODES + NB;
  localparam int TBL_DEPTH = 2 ** TBL_AW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_STEP  = 3'd1;
  localparam logic [2:0] S_ISSUE = 3'd2;
  localparam logic [2:0] S_LAST  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]           state;
  logic [MAX_NODES-1:0] mask;
  logic [NB-1:0]        node_i;
  logic [NB-1:0]        node_j;
  logic [NB-1:0]        node_jd;
  logic                 rd_vld;
  cost_t                acc;
  cost_t                best;

  logic [MAX_NODES-1:0] full;
  logic [MAX_NODES-1:0] bit_i;
  logic [MAX_NODES-1:0] prev;
  logic                 last_i;
  logic                 last_j;
  logic                 is_full;
  logic                 tbl_we;
  logic [TBL_AW-1:0]    tbl_waddr;
  logic [TBL_AW-1:0]    tbl_raddr;
  cost_t                tbl_wdata;
  cost_t                tbl_rdata;
  logic [COST_W:0]      sum;
  logic [COST_W-1:0]    cand_val;
  logic                 cand_ok;
  cost_t                acc_merged;
  cost_t                step_val;
  logic                 step_write;

  always_comb begin
    for (int k = 0; k < MAX_NODES; k++) begin
      full[k] = (NCW'(k) < n_live);
    end
  end

  assign bit_i   = MAX_NODES'(1) << node_i;
  assign prev    = mask & ~bit_i;
  assign is_full = (mask == full);
  assign last_i  = (NCW'(node_i) == n_live - NCW'(1));
  assign last_j  = (NCW'(node_j) == n_live - NCW'(1));

  // candidate from the read issued last cycle
  assign sum      = {1'b0, tbl_rdata.val} + (COST_W + 1)'(adj_rdata[EDGE_W-1:0]);
  assign cand_val = sum[COST_W] ? OUT_MAX : sum[COST_W-1:0];
  assign cand_ok  = rd_vld && prev[node_jd] && adj_rdata[EDGE_W] && tbl_rdata.reach;

  always_comb begin
    acc_merged = acc;
    if (cand_ok && (!acc.reach || (cand_val < acc.val))) begin
      acc_merged = '{reach: 1'b1, val: cand_val};
    end
  end

  // node outside the set, or the set is this node alone
  assign step_write = (state == S_STEP) && (!mask[node_i] || (mask == bit_i));
  assign step_val   = mask[node_i] ? COST_ZERO : COST_NONE;

  assign tbl_we    = step_write || (state == S_LAST);
  assign tbl_wdata = (state == S_LAST) ? acc_merged : step_val;
  assign tbl_waddr = {mask, node_i};
  assign tbl_raddr = {prev, node_j};

  assign adj_raddr = (node_i < node_j) ? {node_i, node_j} : {node_j, node_i};

  bshp_ram #(
    .WIDTH ($bits(cost_t)),
    .DEPTH (TBL_DEPTH)
  ) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rd_vld <= 1'b0;
      best   <= COST_NONE;
    end else begin
      rd_vld  <= (state == S_ISSUE);
      node_jd <= node_j;
      case (state)
        S_IDLE: begin
          if (start) begin
            mask   <= MAX_NODES'(1);
            node_i <= '0;
            best   <= COST_NONE;
            state  <= S_STEP;
          end
        end
        S_STEP: begin
          if (!step_write) begin
            acc    <= COST_NONE;
            node_j <= '0;
            state  <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          acc <= acc_merged;
          if (last_j) begin
            state <= S_LAST;
          end else begin
            node_j <= node_j + NB'(1);
          end
        end
        S_LAST: begin
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // entry written: move to the next (set, end node)
      if (tbl_we) begin
        if (is_full && tbl_wdata.reach && (!best.reach || (tbl_wdata.val < best.val))) begin
          best <= tbl_wdata;
        end
        if (last_i) begin
          node_i <= '0;
          if (is_full) begin
            state <= S_DONE;
          end else begin
            mask  <= mask + MAX_NODES'(1);
            state <= S_STEP;
          end
        end else begin
          node_i <= node_i + NB'(1);
          state  <= S_STEP;
        end
      end
    end
  end

  assign status.busy = (state != S_IDLE);
  assign status.done = (state == S_DONE);
  assign status.best = best;

`ifndef SYNTHESIS
  a_no_read_on_write: assert property (@(posedge clk) disable iff (rst)
    tbl_we |-> !(state == S_ISSUE))
    else $error("table read issued in a write cycle");

  a_last_follows_issue: assert property (@(posedge clk) disable iff (rst)
    (state == S_LAST) |-> $past(state == S_ISSUE) && rd_vld)
    else $error("final merge without a pending read");

  a_done_best_clamped: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && !best.reach |-> best.val == '0)
    else $error("unreachable best carries a value");
`endif

endmodule

`default_nettype wire

// ===== rtl/bitmask_shortest_hamiltonian_path.sv =====
`default_nettype none

// Shortest Hamiltonian path over an undirected weighted graph of up to
// MAX_NODES nodes (node_count in use). Items: cmd 0 clears the graph, cmd 1
// stores edge (node_a, node_b) with weight edge_weight (low WEIGHT_WIDTH bits,
// a later edge on the same pair overwrites), cmd 2 solves and returns one
// result item (path_cost, found); cmd 3 is dropped. Edges with an endpoint at
// or beyond the node count are dropped. After an edge item the next item can
// follow at once. A clear sweeps all 2^(2*ceil(log2(MAX_NODES))) entries of
// the adjacency memory (256 at the default), one entry per cycle; the same
// sweep runs after reset, and no item is taken until it ends (configuration
// writes are). A solve walks the subset table memory in (set, end node)
// order: an entry is written directly when the end node is not in the set
// or is the whole set, else after a setup step, one read of the single
// table read port per node, and a merge and write-back. The block takes no
// item until the result is handed to the output register. The output
// register holds a finished result while the next item is taken. Costs
// above 2^20-1 are reported as 2^20-1 with found set.

module bitmask_shortest_hamiltonian_path import bshp_pkg::*; #(
  parameter int MAX_NODES = 16,
  parameter int WEIGHT_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [NODE_CNT_W-1:0] cfg_data,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            cmd,
  input  logic [3:0]            node_a,
  input  logic [3:0]            node_b,
  input  logic [IN_WEIGHT_W-1:0] edge_weight,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COST_W-1:0]     path_cost,
  output logic                  found
);

  localparam int NB = $clog2(MAX_NODES);
  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int EDGE_W = (WEIGHT_WIDTH < IN_WEIGHT_W) ? WEIGHT_WIDTH : IN_WEIGHT_W;
  localparam int ADJ_AW = 2 * NB;
  localparam int ADJ_DEPTH = 2 ** ADJ_AW;

  logic [NODE_CNT_W-1:0] node_count;
  logic [NCW-1:0]        n_live;

  logic                  clr_active;
  logic [ADJ_AW-1:0]     clr_addr;

  logic                  in_take;
  logic                  edge_load;
  logic                  a_ok;
  logic                  b_ok;
  logic [NB-1:0]         ea;
  logic [NB-1:0]         eb;

  logic                  adj_we;
  logic [ADJ_AW-1:0]     adj_waddr;
  logic [EDGE_W:0]       adj_wdata;
  logic [ADJ_AW-1:0]     adj_raddr;
  logic [EDGE_W:0]       adj_rdata;

  logic                  sol_start;
  logic                  res_take;
  sol_stat_t             sol;

  // configuration: node count, zero acts as one, clamped to MAX_NODES
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_CNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      node_count <= cfg_data;
    end
  end

  always_comb begin
    if (node_count == '0) begin
      n_live = NCW'(1);
    end else if (node_count > NODE_CNT_W'(MAX_NODES)) begin
      n_live = NCW'(MAX_NODES);
    end else begin
      n_live = NCW'(node_count);
    end
  end

  // input side
  assign in_ready  = !clr_active && !sol.busy;
  assign in_take   = in_valid && in_ready;
  assign a_ok      = (NODE_CNT_W'(node_a) < NODE_CNT_W'(n_live));
  assign b_ok      = (NODE_CNT_W'(node_b) < NODE_CNT_W'(n_live));
  assign edge_load = in_take && (cmd == CMD_EDGE) && a_ok && b_ok;
  assign sol_start = in_take && (cmd == CMD_SOLVE);
  assign ea        = NB'(node_a);
  assign eb        = NB'(node_b);

  // clearing sweep, after reset and on a clear item
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + ADJ_AW'(1);
      if (clr_addr == '1) begin
        clr_active <= 1'b0;
      end
    end else if (in_take && (cmd == CMD_CLEAR)) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end
  end

  // adjacency entries are kept once per pair, lower node first
  assign adj_we    = clr_active || edge_load;
  assign adj_waddr = clr_active ? clr_addr : ((ea < eb) ? {ea, eb} : {eb, ea});
  assign adj_wdata = clr_active ? '0 : {1'b1, edge_weight[EDGE_W-1:0]};

  bshp_ram #(
    .WIDTH (EDGE_W + 1),
    .DEPTH (ADJ_DEPTH)
  ) u_adj (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  bshp_solver #(
    .MAX_NODES (MAX_NODES),
    .EDGE_W    (EDGE_W)
  ) u_solver (
    .clk       (clk),
    .rst       (rst),
    .start     (sol_start),
    .take      (res_take),
    .n_live    (n_live),
    .adj_raddr (adj_raddr),
    .adj_rdata (adj_rdata),
    .status    (sol)
  );

  // output register
  assign res_take = sol.done && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      path_cost <= sol.best.reach ? sol.best.val : '0;
      found     <= sol.best.reach;
    end
  end

`ifndef SYNTHESIS
  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> path_cost == '0)
    else $error("not-found result with nonzero cost");

  a_result_waits: assert property (@(posedge clk) disable iff (rst)
    sol.done && out_valid && !out_ready |=> sol.done)
    else $error("solver result lost while output is full");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    in_take && (cmd == CMD_CLEAR) |=> !in_ready)
    else $error("item taken right after a clear");

  a_solve_blocks: assert property (@(posedge clk) disable iff (rst)
    sol_start |=> sol.busy && !in_ready)
    else $error("item taken while a solve runs");
`endif

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import bshp_pkg::*;

  localparam int NODES_MAX = 16;
  localparam int WEIGHT_BITS = 16;
  // A clear sweeps all 256 adjacency entries, so an idle-looking block may still
  // be busy with one.
  localparam int SETTLE_CYCLES = 300;
  // The longest solve here is 11 nodes.
  localparam int WATCHDOG_LIMIT = 700000;
  localparam int RX_HOLD_CYCLES = 4000;
  localparam int REPORT_MAX = 10;

  // cmd 3 is not a defined command; the block drops it
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int unsigned NO_PATH = 32'hFFFF_FFFF;
  localparam int unsigned SUM_CAP = 32'hFFFF_FFFE;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic              reached;
  } path_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [NODE_CNT_W-1:0] cnt;
    logic [1:0]            op;
    logic [3:0]            a;
    logic [3:0]            b;
    logic [15:0]           w;
    bit                    typed;
    path_t                 want;
  } dir_row_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_TRICKLE} rx_mode_e;

  logic                   clk;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [NODE_CNT_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [1:0]             cmd;
  logic [3:0]             node_a;
  logic [3:0]             node_b;
  logic [IN_WEIGHT_W-1:0] edge_weight;
  logic                   out_valid;
  logic                   out_ready;
  logic [COST_W-1:0]      path_cost;
  logic                   found;

  bitmask_shortest_hamiltonian_path #(
    .MAX_NODES    (NODES_MAX),
    .WEIGHT_WIDTH (WEIGHT_BITS)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .node_a      (node_a),
    .node_b      (node_b),
    .edge_weight (edge_weight),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .path_cost   (path_cost),
    .found       (found)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Graph model: node count register, adjacency store, and the subset table
  // for the Held-Karp pass. One table row per visited set, 16 end-node slots.
  // ---------------------------------------------------------------------------
  logic [NODE_CNT_W-1:0] model_node_count;
  logic                  graph_ok [NODES_MAX][NODES_MAX];
  logic [31:0]           graph_w  [NODES_MAX][NODES_MAX];
  int unsigned           subset_cost [1 << 20];

  path_t expected_paths [$];
  dir_row_t dir_rows [$];

  int err_count = 0;
  int burst_left;
  logic hold_req;

  // 0 acts as 1, anything above the node limit acts as the limit
  function automatic int unsigned live_node_total();
    int unsigned n;
    n = model_node_count;
    if (n == 0) n = 1;
    if (n > NODES_MAX) n = NODES_MAX;
    return n;
  endfunction

  function automatic path_t cheapest_full_path();
    int unsigned n, full, vis, prev, i, j, c, sum, best;
    longint unsigned s;
    path_t r;
    n = live_node_total();
    full = (1 << n) - 1;
    best = NO_PATH;
    for (vis = 1; vis <= full; vis++) begin
      for (i = 0; i < n; i++) begin
        c = NO_PATH;
        if (vis == (1 << i)) begin
          c = 0;
        end else if (((vis >> i) & 1) != 0) begin
          prev = vis ^ (1 << i);
          for (j = 0; j < n; j++) begin
            // unreachable predecessors are skipped, never added to
            if (((prev >> j) & 1) != 0 && graph_ok[i][j] &&
                subset_cost[prev * NODES_MAX + j] != NO_PATH) begin
              s = longint'(subset_cost[prev * NODES_MAX + j]) + longint'(graph_w[i][j]);
              sum = (s > SUM_CAP) ? SUM_CAP : s[31:0];
              if (sum < c) c = sum;
            end
          end
        end
        subset_cost[vis * NODES_MAX + i] = c;
      end
    end
    for (i = 0; i < n; i++) begin
      if (subset_cost[full * NODES_MAX + i] < best) best = subset_cost[full * NODES_MAX + i];
    end
    if (best == NO_PATH) begin
      r.cost = '0;
      r.reached = 1'b0;
    end else begin
      r.cost = (best > OUT_MAX) ? OUT_MAX : best[COST_W-1:0];
      r.reached = 1'b1;
    end
    return r;
  endfunction

  // Applies one accepted item to the model; returns 1 when it yields a result.
  function automatic bit apply_graph_item(input logic [1:0] op, input logic [3:0] a,
                                          input logic [3:0] b, input logic [15:0] w,
                                          output path_t res);
    int unsigned n, x, y;
    n = live_node_total();
    res = '0;
    case (op)
      CMD_CLEAR: begin
        for (x = 0; x < NODES_MAX; x++) begin
          for (y = 0; y < NODES_MAX; y++) begin
            graph_ok[x][y] = 1'b0;
            graph_w[x][y] = '0;
          end
        end
      end
      CMD_EDGE: begin
        // endpoints past the live node count are dropped; self loops are kept
        if (a < n && b < n) begin
          graph_ok[a][b] = 1'b1;
          graph_ok[b][a] = 1'b1;
          graph_w[a][b] = 32'(w & ((1 << WEIGHT_BITS) - 1));
          graph_w[b][a] = 32'(w & ((1 << WEIGHT_BITS) - 1));
        end
      end
      CMD_SOLVE: begin
        res = cheapest_full_path();
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Bursts of 1..24 items; a quarter of bursts follow on with no gap.
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  // Valid stays high after the accepting edge; whoever drives next either
  // replaces the payload or lowers valid at the following falling edge.
  task automatic push_item(input logic [1:0] op, input logic [3:0] a, input logic [3:0] b,
                           input logic [15:0] w, input bit typed, input path_t typed_res);
    path_t res;
    bit has_res;
    pace_sender();
    @(negedge clk);
    in_valid = 1'b1;
    cmd = op;
    node_a = a;
    node_b = b;
    edge_weight = w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    has_res = apply_graph_item(op, a, b, w, res);
    if (has_res) expected_paths.insert(expected_paths.size(), typed ? typed_res : res);
  endtask

  // Register writes only once the block has drained and any clear has swept.
  task automatic write_node_count(input logic [NODE_CNT_W-1:0] v);
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_paths.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_node_count = v;
    @(negedge clk);
    cfg_valid = 1'b0;
    burst_left = 0;
  endtask

  task automatic add_cfg_row(input logic [NODE_CNT_W-1:0] v);
    dir_row_t row;
    row = '{kind: ROW_CFG, cnt: v, op: CMD_CLEAR, a: '0, b: '0, w: '0, typed: 1'b0,
            want: '0};
    dir_rows.insert(dir_rows.size(), row);
  endtask

  task automatic add_item_row(input logic [1:0] op, input logic [3:0] a, input logic [3:0] b,
                              input logic [15:0] w, input bit typed,
                              input logic [COST_W-1:0] cost, input logic reached);
    dir_row_t row;
    row.kind = ROW_ITEM;
    row.cnt = '0;
    row.op = op;
    row.a = a;
    row.b = b;
    row.w = w;
    row.typed = typed;
    row.want.cost = cost;
    row.want.reached = reached;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  function automatic logic [3:0] pick_node(input int unsigned n);
    // mostly live endpoints, now and then any endpoint (may be dropped)
    if ($urandom_range(0, 9) == 0) return 4'($urandom_range(0, 15));
    return 4'($urandom_range(0, n - 1));
  endfunction

  function automatic logic [15:0] pick_weight();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern that changes mode at random, plus
  // one long hold-off when the stimulus asks for it.
  // ---------------------------------------------------------------------------
  rx_mode_e rx_mode;
  int rx_left;
  int hold_left;
  bit hold_done;

  initial begin
    out_ready = 1'b0;
    rx_mode = RX_OPEN;
    rx_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = RX_HOLD_CYCLES;
      end
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 2));
        rx_left = $urandom_range(50, 300);
      end
      rx_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:  out_ready = 1'b1;
          RX_COIN:  out_ready = 1'($urandom_range(0, 1));
          default:  out_ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: capture at the rising edge, compare at the falling edge.
  // ---------------------------------------------------------------------------
  logic              got_valid;
  logic [COST_W-1:0] got_cost;
  logic              got_found;
  path_t             want;

  always @(posedge clk) begin
    got_valid <= !rst && out_valid && out_ready;
    got_cost  <= path_cost;
    got_found <= found;
  end

  always @(negedge clk) begin
    if (got_valid === 1'b1) begin
      if (expected_paths.size() == 0) begin
        err_count++;
        if (err_count <= REPORT_MAX)
          $display("%0t: result item with none expected: cost %0d found %0b",
                   $realtime, got_cost, got_found);
      end else begin
        want = expected_paths.pop_front();
        if (got_cost !== want.cost || got_found !== want.reached) begin
          err_count++;
          if (err_count <= REPORT_MAX)
            $display("%0t: path mismatch: expected cost %0d found %0b, got cost %0d found %0b",
                     $realtime, want.cost, want.reached, got_cost, got_found);
        end
      end
    end
  end

  // Watchdog: too long with no handshake on any channel.
  int quiet_cycles;

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("testbench failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int phase, n_sel, n_live, n_edges, r, work_items, solve_items;
    path_t clr_res;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    cmd = CMD_CLEAR;
    node_a = '0;
    node_b = '0;
    edge_weight = '0;
    hold_req = 1'b0;
    burst_left = 0;
    model_node_count = NODE_CNT_RESET;
    void'(apply_graph_item(CMD_CLEAR, '0, '0, '0, clr_res));

    // Directed table. Typed expectations only where the answer is obvious.
    add_cfg_row(5'd0);                                        // zero acts as one node
    add_item_row(CMD_SOLVE, 0, 0, 0, 1, 20'd0, 1'b1);         // single node: cost 0
    add_item_row(CMD_EDGE, 0, 1, 16'd5, 0, '0, 1'b0);         // endpoint 1 dropped at n=1
    add_cfg_row(5'd2);
    add_item_row(CMD_SOLVE, 0, 0, 0, 1, 20'd0, 1'b0);         // no edge: not found
    add_item_row(CMD_EDGE, 0, 1, 16'hFFFF, 0, '0, 1'b0);      // heaviest weight
    add_item_row(CMD_SOLVE, 0, 0, 0, 1, 20'd65535, 1'b1);
    add_item_row(CMD_EDGE, 1, 0, 16'h0000, 0, '0, 1'b0);      // overwrite, reversed pair
    add_item_row(CMD_SOLVE, 0, 0, 0, 1, 20'd0, 1'b1);
    add_item_row(CMD_EDGE, 0, 0, 16'd7, 0, '0, 1'b0);         // self loop, never used
    add_item_row(CMD_UNUSED, 15, 15, 16'hFFFF, 0, '0, 1'b0);  // dropped command
    add_item_row(CMD_SOLVE, 0, 0, 0, 0, '0, 1'b0);
    add_item_row(CMD_CLEAR, 0, 0, 0, 0, '0, 1'b0);
    add_item_row(CMD_SOLVE, 0, 0, 0, 1, 20'd0, 1'b0);         // cleared: not found
    add_cfg_row(5'd31);                                       // above limit acts as 16
    add_item_row(CMD_EDGE, 15, 15, 16'hFFFF, 0, '0, 1'b0);
    add_item_row(CMD_EDGE, 14, 15, 16'h8000, 0, '0, 1'b0);
    add_item_row(CMD_EDGE, 0, 1, 16'd1, 0, '0, 1'b0);
    add_item_row(CMD_EDGE, 1, 2, 16'd2, 0, '0, 1'b0);
    add_item_row(CMD_EDGE, 2, 3, 16'd3, 0, '0, 1'b0);
    add_item_row(CMD_EDGE, 3, 0, 16'd100, 0, '0, 1'b0);
    add_cfg_row(5'd4);
    add_item_row(CMD_EDGE, 4, 3, 16'd9, 0, '0, 1'b0);         // endpoint 4 dropped at n=4
    add_item_row(CMD_SOLVE, 0, 0, 0, 0, '0, 1'b0);
    add_cfg_row(5'd5);
    add_item_row(CMD_SOLVE, 0, 0, 0, 1, 20'd0, 1'b0);         // node 4 isolated
    add_cfg_row(5'd16);
    add_item_row(CMD_EDGE, 15, 4, 16'hAAAA, 0, '0, 1'b0);
    add_item_row(CMD_EDGE, 4, 3, 16'h5555, 0, '0, 1'b0);
    add_cfg_row(5'd5);
    add_item_row(CMD_SOLVE, 0, 0, 0, 0, '0, 1'b0);
    add_cfg_row(5'd1);
    add_item_row(CMD_SOLVE, 0, 0, 0, 1, 20'd0, 1'b1);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_CFG)
        write_node_count(dir_rows[k].cnt);
      else
        push_item(dir_rows[k].op, dir_rows[k].a, dir_rows[k].b, dir_rows[k].w,
                  dir_rows[k].typed, dir_rows[k].want);
    end

    // Random phases: node count write, usually a clear, mostly edges, one closing
    // solve, except phase 2. Small graphs keep solves short; one 11-node phase goes deep.
    phase = 0;
    work_items = 0;
    solve_items = 0;
    while (work_items < 500 || solve_items < 40) begin
      if (phase == 0) begin
        n_sel = 11;
      end else if (phase == 2) begin
        n_sel = 4;
      end else begin
        r = $urandom_range(0, 19);
        if (r == 0) n_sel = 0;
        else if (r == 1) n_sel = 9;
        else n_sel = $urandom_range(1, 8);
      end
      write_node_count(NODE_CNT_W'(n_sel));
      n_live = live_node_total();

      if (phase == 2) begin
        // Receiver holds off while solves keep coming: the output register
        // fills, the next solve cannot hand off, and the input stalls.
        hold_req = 1'b1;
        push_item(CMD_CLEAR, 0, 0, 0, 0, '0);
        push_item(CMD_EDGE, 0, 1, pick_weight(), 0, '0);
        push_item(CMD_EDGE, 1, 2, pick_weight(), 0, '0);
        push_item(CMD_EDGE, 2, 3, pick_weight(), 0, '0);
        repeat (4) begin
          push_item(CMD_SOLVE, 0, 0, 0, 0, '0);
          push_item(CMD_EDGE, pick_node(n_live), pick_node(n_live), pick_weight(), 0, '0);
        end
        work_items += 12;
        solve_items += 4;
      end else begin
        // one phase in ten skips the clear and builds on the old graph
        if ($urandom_range(0, 9) != 0) begin
          push_item(CMD_CLEAR, 0, 0, 0, 0, '0);
          work_items++;
        end
        n_edges = $urandom_range(0, n_live * n_live);
        repeat (n_edges) begin
          r = $urandom_range(0, 99);
          if (r < 4) begin
            push_item(CMD_UNUSED, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                      16'($urandom_range(0, 16'hFFFF)), 0, '0);
          end else if (r < 9 && n_live <= 8) begin
            push_item(CMD_SOLVE, pick_node(n_live), pick_node(n_live), pick_weight(), 0, '0);
            work_items++;
            solve_items++;
          end else if (r < 11 && phase != 0) begin
            push_item(CMD_CLEAR, pick_node(n_live), pick_node(n_live), pick_weight(), 0, '0);
            work_items++;
          end else begin
            push_item(CMD_EDGE, pick_node(n_live), pick_node(n_live), pick_weight(), 0, '0);
            work_items++;
          end
        end
        push_item(CMD_SOLVE, 0, 0, 0, 0, '0);
        work_items++;
        solve_items++;
      end
      phase++;
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (expected_paths.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
